// File: rtl/indel_offset_accounting_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indel offset accounting table
// Concurrent assertion wrappers for the port-level checker file.
// ----------------------------------------------------------------------------
`ifndef INDEL_OFFSET_ACCOUNTING_TABLE_TOP_MACROS_SVH
`define INDEL_OFFSET_ACCOUNTING_TABLE_TOP_MACROS_SVH

// Checked outside reset only.
`define IAOT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define IAOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/iaot_pkg.sv
// ----------------------------------------------------------------------------
// iaot_pkg
// Shared types and constants of the indel offset accounting table.
// ----------------------------------------------------------------------------
package iaot_pkg;

    localparam int POS_W   = 32;
    localparam int CHG_W   = 32;
    localparam int OUT_W   = 40;
    localparam int ST_W    = 2;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 88;

    typedef enum logic [ST_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DUP  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // One queued transaction, already classified.
    typedef struct packed {
        logic [POS_W-1:0]        position;
        logic signed [CHG_W-1:0] length_change;
        logic                    is_write;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

// File: rtl/iaot_ram.sv
// ----------------------------------------------------------------------------
// iaot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iaot_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/iaot_front.sv
// ----------------------------------------------------------------------------
// iaot_front
// Input side: accepts transactions, tags query versus write, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module iaot_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [iaot_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           q_valid,
    output iaot_pkg::item_t                q_item,
    input  logic                           q_pop
);
    import iaot_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       in_item;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        in_item.position      = s_tdata[POS_W-1:0];
        in_item.length_change = s_tdata[POS_W +: CHG_W];
        in_item.is_write      = (s_tdata[POS_W +: CHG_W] != '0);
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/iaot_back.sv
// ----------------------------------------------------------------------------
// iaot_back
// Execution side: walks the record table one entry per cycle, sums the
// changes at or below the item position, checks for a duplicate, then
// inserts a new write if the table has room and posts the result.
// ----------------------------------------------------------------------------
module iaot_back #(
    parameter int MAX_RECORDS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  iaot_pkg::item_t                q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iaot_pkg::M_DATA_W-1:0]  m_tdata
);
    import iaot_pkg::*;

    localparam int AW    = $clog2(MAX_RECORDS);
    localparam int CW    = $clog2(MAX_RECORDS + 1);
    localparam int TOT_W = CHG_W + AW + 1;
    localparam int REC_W = POS_W + CHG_W;

    back_state_t              state_reg, state_next;
    item_t                    item_reg;
    logic [CW-1:0]            idx_reg;
    logic                     pend_reg;
    logic signed [TOT_W-1:0]  acc_reg;
    logic                     dup_reg;
    logic [CW-1:0]            count_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic                     m_valid_reg;
    logic [M_DATA_W-1:0]      m_data_reg;

    logic                     start, issue, finish_go, out_free, scan_done;
    logic [REC_W-1:0]         rd_data;
    logic [POS_W-1:0]         rd_pos;
    logic signed [CHG_W-1:0]  rd_chg;
    logic                     full;
    logic                     do_insert;
    status_t                  status;
    logic signed [TOT_W-1:0]  total_new;
    logic [OUT_W-1:0]         adj_out, tot_out;

    iaot_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (do_insert),
        .waddr (count_reg[AW-1:0]),
        .wdata ({item_reg.length_change, item_reg.position}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign rd_pos    = rd_data[POS_W-1:0];
    assign rd_chg    = rd_data[POS_W +: CHG_W];
    assign out_free  = !m_valid_reg || m_tready;
    assign full      = (count_reg == CW'(MAX_RECORDS));
    assign scan_done = (idx_reg == count_reg) && !pend_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_SCAN;
            ST_SCAN:   if (scan_done) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        start     = 1'b0;
        issue     = 1'b0;
        finish_go = 1'b0;
        unique case (state_reg)
            ST_IDLE:   start = q_valid;
            ST_SCAN:   issue = (idx_reg != count_reg);
            ST_FINISH: finish_go = out_free;
            default: ;
        endcase
    end

    assign q_pop = start;

    always_comb begin
        status    = STATUS_OK;
        do_insert = 1'b0;
        if (item_reg.is_write) begin
            priority if (dup_reg) begin
                status = STATUS_DUP;
            end else if (full) begin
                status = STATUS_FULL;
            end else begin
                do_insert = finish_go;
            end
        end
        total_new = total_reg;
        if (item_reg.is_write && !dup_reg && !full) begin
            total_new = total_reg + TOT_W'(item_reg.length_change);
        end
    end

    // clamp sums to the 40-bit output range, or sign-extend them when they fit
    generate
        if (TOT_W > OUT_W) begin : g_sat
            always_comb begin
                if (acc_reg[TOT_W-1:OUT_W-1] == '0 || acc_reg[TOT_W-1:OUT_W-1] == '1) begin
                    adj_out = acc_reg[OUT_W-1:0];
                end else begin
                    adj_out = acc_reg[TOT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                               : {1'b0, {(OUT_W-1){1'b1}}};
                end
                if (total_new[TOT_W-1:OUT_W-1] == '0
                        || total_new[TOT_W-1:OUT_W-1] == '1) begin
                    tot_out = total_new[OUT_W-1:0];
                end else begin
                    tot_out = total_new[TOT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                 : {1'b0, {(OUT_W-1){1'b1}}};
                end
            end
        end else begin : g_ext
            assign adj_out = OUT_W'(acc_reg);
            assign tot_out = OUT_W'(total_new);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (start) begin
                idx_reg <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (finish_go) begin
                total_reg <= total_new;
                if (do_insert) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (finish_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            item_reg <= q_item;
            acc_reg  <= '0;
            dup_reg  <= 1'b0;
        end else if (pend_reg) begin
            // read data arrives in the cycle after its address
            if (rd_pos <= item_reg.position) begin
                acc_reg <= acc_reg + TOT_W'(rd_chg);
            end
            if (rd_pos == item_reg.position) begin
                dup_reg <= 1'b1;
            end
        end
        if (finish_go) begin
            m_data_reg <= {{(M_DATA_W - 2*OUT_W - ST_W){1'b0}}, tot_out, status, adj_out};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/indel_offset_accounting_table_top.sv
// ----------------------------------------------------------------------------
// indel_offset_accounting_table_top
// Table of indel records with per-item offset sums and running total.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one variant per transaction: position and signed
//   length change. A zero change is a query and stores nothing.
//   m_ channel returns exactly one result per input: offset adjustment
//   (sum of stored changes at or below the position, before insert),
//   status (ok, duplicate rejected, table full) and the running total.
//   The back end takes one item at a time from the queue head, scans
//   every stored record, then posts the result, so the time per item
//   grows with the number of stored records. The record table sits in a
//   single-port-read RAM with registered read data, scanned one entry per
//   cycle.
//   A two-entry input queue keeps s_tready high while the back end works
//   or a result waits for m_tready.
//   Reset (aresetn low, synchronous) empties the table and queue and
//   clears the running total; no clearing pass is needed.
//   A stalled m_ side holds the result; the back end waits before posting
//   the next one, and the queue backs up to s_tready low once full.
// ----------------------------------------------------------------------------
module indel_offset_accounting_table_top #(
    parameter int MAX_RECORDS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] position, [63:32] length_change
    input  logic [iaot_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [39:0] offset_adjust, [41:40] status, [81:42] total_change, [87:82] zero
    output logic [iaot_pkg::M_DATA_W-1:0]  m_tdata
);
    import iaot_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    iaot_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    iaot_back #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/iaot_checker.sv
// ----------------------------------------------------------------------------
// iaot_checker
// Port-level assertions for the indel offset accounting table.
// ----------------------------------------------------------------------------
`include "indel_offset_accounting_table_top_macros.svh"

module iaot_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [iaot_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [iaot_pkg::M_DATA_W-1:0]  m_tdata
);
    import iaot_pkg::*;

    // offered input is held until accepted
    `IAOT_ASSERT(a_s_hold, aclk, aresetn, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata), "input changed while stalled")

    // held result must not change while stalled
    `IAOT_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // status code 3 is never produced
    `IAOT_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> (m_tdata[41:40] == STATUS_OK || m_tdata[41:40] == STATUS_DUP || m_tdata[41:40] == STATUS_FULL), "illegal status")

    // reset drops the output valid
    `IAOT_ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // pad bits of the result stay zero
    `IAOT_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[87:82] == 6'd0, "nonzero pad bits")

endmodule

bind indel_offset_accounting_table_top iaot_checker u_iaot_checker (.*);

// File: bench/iaot_result_checker.sv
// ----------------------------------------------------------------------------
// iaot_result_checker
// Watches both stream channels of the indel offset table, predicts one result
// per accepted input transaction and compares each output transaction field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module iaot_result_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [31:0] position, [63:32] length_change
    input  logic [iaot_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [39:0] offset_adjust, [41:40] status, [81:42] total_change, [87:82] zero
    input  logic [iaot_pkg::M_DATA_W-1:0]  m_tdata,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import iaot_pkg::*;

    localparam int ADJ_LSB = 0;
    localparam int ST_LSB  = OUT_W;
    localparam int TOT_LSB = OUT_W + ST_W;
    localparam int PAD_LSB = 2 * OUT_W + ST_W;

    typedef struct packed {
        logic signed [OUT_W-1:0] offset_adjust;
        status_t                 status;
        logic signed [OUT_W-1:0] total_change;
    } table_result_t;

    // Shadow copy of the record table
    logic [POS_W-1:0]        rec_pos [TABLE_DEPTH];
    logic signed [CHG_W-1:0] rec_chg [TABLE_DEPTH];
    int                      rec_count;
    longint                  run_total;

    table_result_t pending_results [$];
    int            result_idx;

    function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (OUT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        return v[OUT_W-1:0];
    endfunction

    // Sum over stored records, then insert unless duplicate or full.
    function automatic table_result_t apply_variant(input logic [POS_W-1:0] pos,
                                                    input logic signed [CHG_W-1:0] chg);
        table_result_t r;
        longint        adjust;
        bit            dup;
        adjust = 0;
        dup    = 1'b0;
        for (int i = 0; i < rec_count; i++) begin
            if (rec_pos[i] <= pos)
                adjust += longint'(rec_chg[i]);
            if (rec_pos[i] == pos)
                dup = 1'b1;
        end
        r.status = STATUS_OK;
        if (chg != 0) begin
            if (dup) begin
                r.status = STATUS_DUP;
            end else if (rec_count >= TABLE_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                rec_pos[rec_count] = pos;
                rec_chg[rec_count] = chg;
                rec_count++;
                run_total += longint'(chg);
            end
        end
        r.offset_adjust = clamp_out(adjust);
        r.total_change  = clamp_out(run_total);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] result %0d mismatch: %s", $time, result_idx, msg);
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] beat);
        table_result_t want;
        logic signed [OUT_W-1:0] got_adj;
        logic signed [OUT_W-1:0] got_tot;
        if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected transaction tdata=%h", beat));
            return;
        end
        want    = pending_results.pop_front();
        got_adj = beat[ADJ_LSB +: OUT_W];
        got_tot = beat[TOT_LSB +: OUT_W];
        if (got_adj !== want.offset_adjust)
            note_failure($sformatf("offset_adjust exp %0d got %0d",
                                   want.offset_adjust, got_adj));
        if (beat[ST_LSB +: ST_W] !== want.status)
            note_failure($sformatf("status exp %0d got %0d",
                                   want.status, beat[ST_LSB +: ST_W]));
        if (got_tot !== want.total_change)
            note_failure($sformatf("total_change exp %0d got %0d",
                                   want.total_change, got_tot));
        if (beat[M_DATA_W-1:PAD_LSB] !== '0)
            note_failure($sformatf("pad bits exp 0 got %h", beat[M_DATA_W-1:PAD_LSB]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rec_count  = 0;
            run_total  = 0;
            result_idx = 0;
            fail_count = 0;
            pending_results.delete();
            outstanding <= 0;
        end else begin
            // result side first so a same-cycle input never matches itself
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                result_idx++;
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_variant(s_tdata[POS_W-1:0],
                                                        s_tdata[S_DATA_W-1:POS_W]));
            outstanding <= pending_results.size();
        end
    end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the indel offset accounting table: directed
// extremes and special cases, then random variants with position reuse to
// hit duplicates and a full table, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iaot_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int RANDOM_ITEMS = 1134;
    localparam int HOLD_CYCLES  = 2000;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 300;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;

    logic steady       = 1'b0;
    logic hold_request = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   stall_cycles = 0;

    logic [POS_W-1:0] used_pos [$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    indel_offset_accounting_table_top #(
        .MAX_RECORDS (TABLE_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    iaot_result_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Receiver: random idling, one long hold-off once requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    function automatic logic [POS_W-1:0] pick_position();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return POS_W'($urandom_range(0, 127));
        if (sel < 55 && used_pos.size() != 0)
            return used_pos[$urandom_range(0, used_pos.size() - 1)];
        if (sel < 65)
            return 32'hFFFF_FFFF - POS_W'($urandom_range(0, 3));
        return $urandom();
    endfunction

    function automatic logic [CHG_W-1:0] pick_change();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 22)
            return '0;
        if (sel < 30)
            return 32'h7FFF_FFFF;
        if (sel < 38)
            return 32'h8000_0000;
        if (sel < 46)
            return ($urandom_range(0, 1) != 0) ? 32'h0000_0001 : 32'hFFFF_FFFF;
        if (sel < 60)
            return CHG_W'($urandom_range(0, 200)) - 32'd100;
        return $urandom();
    endfunction

    task automatic send_variant(input logic [POS_W-1:0] pos, input logic [CHG_W-1:0] chg);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {chg, pos};
        do @(posedge aclk); while (!s_tready);
        if (used_pos.size() < 512)
            used_pos.push_back(pos);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Watchdog: cycles with no transaction on either channel.
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("indel_offset_accounting_table_top verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // queries on an empty table
        send_variant(32'h0000_0000, 32'h0000_0000);
        send_variant(32'hFFFF_FFFF, 32'h0000_0000);
        // extreme positions and changes
        send_variant(32'h0000_0000, 32'h7FFF_FFFF);
        send_variant(32'hFFFF_FFFF, 32'h8000_0000);
        send_variant(32'hFFFF_FFFF, 32'h0000_0000);
        send_variant(32'h0000_0000, 32'h0000_0000);
        // duplicates, then a zero change at a stored position
        send_variant(32'h0000_0000, 32'h0000_0001);
        send_variant(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_variant(32'h0000_0000, 32'h0000_0000);
        // neighbors around the compare boundary
        send_variant(32'd1000, 32'h0000_0001);
        send_variant(32'd999, 32'hFFFF_FFFF);
        send_variant(32'd999, 32'h0000_0000);
        send_variant(32'd1000, 32'h0000_0000);
        send_variant(32'h7FFF_FFFF, 32'h8000_0000);
        send_variant(32'h8000_0000, 32'h7FFF_FFFF);
        send_variant(32'h7FFF_FFFF, 32'h0000_0000);

        // random part; the table fills up partway through
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady <= (n >= 650 && n < 850);
            if (n == 300)
                hold_request <= 1'b1;
            if (n == 500)
                wait_drained();
            send_variant(pick_position(), pick_change());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("indel_offset_accounting_table_top verification clean");
        else
            $display("indel_offset_accounting_table_top verification failed");
        $finish;
    end

endmodule
